// ----- sv/tea_block_cipher_chained_core_assert.svh -----
// ----------------------------------------------------------------------------
// TEA chained core assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef TEA_BLOCK_CIPHER_CHAINED_CORE_ASSERT_SVH
`define TEA_BLOCK_CIPHER_CHAINED_CORE_ASSERT_SVH

// same-cycle implication
`define TBC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TBC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/tbc_pkg.sv -----
// ----------------------------------------------------------------------------
// TEA chained core package
// Constants, register map, cell word type and the TEA mix function.
// ----------------------------------------------------------------------------
package tbc_pkg;

   localparam logic [31:0] TEA_DELTA     = 32'h9E3779B9;
   localparam logic [31:0] DEC_SUM_RESET = 32'hC6EF3720;  // delta * 32
   localparam logic [6:0]  ROUNDS_RESET  = 7'd32;

   localparam int NUM_CELLS  = 254;                        // two cells per TEA cycle
   localparam int CELL_IDX_W = 8;
   localparam int CSR_ADDR_W = 5;

   localparam logic [2:0] REG_KEY0   = 3'd0;
   localparam logic [2:0] REG_KEY1   = 3'd1;
   localparam logic [2:0] REG_KEY2   = 3'd2;
   localparam logic [2:0] REG_KEY3   = 3'd3;
   localparam logic [2:0] REG_ROUNDS = 3'd4;

   typedef struct packed {
      logic        valid;
      logic        decrypt;
      logic        chained;
      logic        first_block;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] sum;
   } tbc_item_type;

   typedef struct packed {
      logic [3:0][31:0] key;
      logic [6:0]       rounds;
      logic [31:0]      dec_sum;
   } tbc_cfg_type;

   localparam tbc_item_type IDLE_ITEM = '0;

   function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] sum,
                                           input logic [31:0] k0, input logic [31:0] k1);
      return ((v << 4) + k0) ^ (v + sum) ^ ((v >> 5) + k1);
   endfunction

endpackage

// ----- sv/tbc_if.sv -----
// ----------------------------------------------------------------------------
// TEA chained core channels
// Valid/ready word channels for blocks in and results out.
// ----------------------------------------------------------------------------
interface tbc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic        first_block;
   logic [31:0] block_high;
   logic [31:0] block_low;

   modport source (output valid, output mode, output first_block, output block_high,
                   output block_low, input ready);
   modport sink   (input valid, input mode, input first_block, input block_high,
                   input block_low, output ready);
endinterface

interface tbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_high;
   logic [31:0] result_low;

   modport source (output valid, output result_high, output result_low, input ready);
   modport sink   (input valid, input result_high, input result_low, output ready);
endinterface

// ----- sv/tbc_cell.sv -----
// ----------------------------------------------------------------------------
// TEA half-round cell
// One Feistel half-round per cell; even cells do the first half of a TEA
// cycle, odd cells the second half and the sum step.
// ----------------------------------------------------------------------------
module tbc_cell import tbc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             phase,
   input  logic [3:0][31:0] key,
   input  logic             inject,
   input  tbc_item_type     inj_item,
   input  tbc_item_type     prev_item,
   output tbc_item_type     out_item
);

   tbc_item_type src;
   tbc_item_type item_in;
   tbc_item_type item_ff;
   logic         valid_ff;
   logic         valid_in;
   logic         to_y;
   logic [31:0]  mix_v;
   logic [31:0]  mix_ka;
   logic [31:0]  mix_kb;
   logic [31:0]  mix_out;
   logic [31:0]  target;
   logic [31:0]  updated;

   assign src     = inject ? inj_item : prev_item;
   assign to_y    = (phase == src.decrypt);
   assign mix_v   = to_y ? src.z : src.y;
   assign mix_ka  = to_y ? key[0] : key[2];
   assign mix_kb  = to_y ? key[1] : key[3];
   assign mix_out = tea_mix(mix_v, src.sum, mix_ka, mix_kb);
   assign target  = to_y ? src.y : src.z;
   assign updated = src.decrypt ? (target - mix_out) : (target + mix_out);

   always_comb begin
      item_in = src;
      if (to_y) begin
         item_in.y = updated;
      end else begin
         item_in.z = updated;
      end
      if (phase) begin
         item_in.sum = src.decrypt ? (src.sum - TEA_DELTA) : (src.sum + TEA_DELTA);
      end
   end

   assign valid_in = advance ? src.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   always_comb begin
      out_item       = item_ff;
      out_item.valid = valid_ff;
   end

endmodule

// ----- sv/tbc_csr.sv -----
// ----------------------------------------------------------------------------
// TEA chained core register file
// APB key and round-count registers; keeps delta times rounds for decrypt.
// ----------------------------------------------------------------------------
module tbc_csr import tbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output tbc_cfg_type           cfg
);

   logic [3:0][31:0] key_ff, key_in;
   logic [6:0]       rounds_ff, rounds_in;
   logic [31:0]      dec_sum_ff, dec_sum_in;
   logic [38:0]      prod;
   logic             wr;
   logic [2:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign prod       = 39'(TEA_DELTA) * 39'(csr_pwdata[6:0]);

   always_comb begin
      key_in     = key_ff;
      rounds_in  = rounds_ff;
      dec_sum_in = dec_sum_ff;
      if (wr) begin
         unique case (reg_idx)
            REG_KEY0: begin
               key_in[0] = csr_pwdata;
            end
            REG_KEY1: begin
               key_in[1] = csr_pwdata;
            end
            REG_KEY2: begin
               key_in[2] = csr_pwdata;
            end
            REG_KEY3: begin
               key_in[3] = csr_pwdata;
            end
            REG_ROUNDS: begin
               rounds_in  = csr_pwdata[6:0];
               dec_sum_in = prod[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_KEY0:   csr_prdata = key_ff[0];
         REG_KEY1:   csr_prdata = key_ff[1];
         REG_KEY2:   csr_prdata = key_ff[2];
         REG_KEY3:   csr_prdata = key_ff[3];
         REG_ROUNDS: csr_prdata = {25'd0, rounds_ff};
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         rounds_ff  <= ROUNDS_RESET;
         dec_sum_ff <= DEC_SUM_RESET;
      end else begin
         key_ff     <= key_in;
         rounds_ff  <= rounds_in;
         dec_sum_ff <= dec_sum_in;
      end
   end

   assign cfg.key     = key_ff;
   assign cfg.rounds  = rounds_ff;
   assign cfg.dec_sum = dec_sum_ff;

endmodule

// ----- sv/tea_block_cipher_chained_core.sv -----
// ----------------------------------------------------------------------------
// TEA chained block cipher core
// A word enters the row of 254 half-round cells at cell 254 - 2*round_count
// and leaves at the end, then sits in an output register (round_count 0
// goes straight there). Plain-mode words enter one per cycle while the
// result channel is not stalled. A chained word, which needs the chain
// registers left by the words before it, enters only once no chained or
// first-block word is still in the cell row, so it is not taken while an
// earlier chained word is still in the row. A stalled result stalls the
// whole row.
// ----------------------------------------------------------------------------
module tea_block_cipher_chained_core import tbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tbc_req_if.sink               req_chan,
   tbc_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   tbc_cfg_type           cfg;
   logic                  rounds_zero;
   logic [CELL_IDX_W-1:0] inject_idx;

   logic [63:0] chain_inner_ff, chain_inner_in;
   logic [63:0] chain_outer_ff, chain_outer_in;
   logic [63:0] side_ff, side_in;
   logic [CELL_IDX_W-1:0] pend_ff, pend_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_high_ff, out_high_in;
   logic [31:0] out_low_ff, out_low_in;

   logic        advance;
   logic        accept;
   logic        exit_word;
   logic        pend_inc;
   logic        pend_dec;
   logic        req_chained;
   logic [63:0] req_blk;
   logic [63:0] entry_blk;
   logic [63:0] eff_in_inner;
   logic [63:0] eff_in_outer;
   logic [63:0] tail_blk;
   logic [63:0] tail_side;
   logic [63:0] tail_inner;
   logic [63:0] tail_outer;
   logic [63:0] res;

   tbc_item_type entry_item;
   tbc_item_type tail_item;
   tbc_item_type cell_q    [NUM_CELLS];
   tbc_item_type cell_prev [NUM_CELLS];

   tbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign rounds_zero = (cfg.rounds == '0);
   assign inject_idx  = CELL_IDX_W'(NUM_CELLS) - {cfg.rounds, 1'b0};

   // entry side
   assign advance      = !out_valid_ff || rsp_chan.ready;
   assign req_chained  = req_chan.mode[1];
   assign req_blk      = {req_chan.block_high, req_chan.block_low};
   assign eff_in_inner = req_chan.first_block ? '0 : chain_inner_ff;
   assign eff_in_outer = req_chan.first_block ? '0 : chain_outer_ff;

   always_comb begin
      if (!req_chained) begin
         entry_blk = req_blk;
      end else if (req_chan.mode[0]) begin
         entry_blk = req_blk ^ eff_in_inner;
      end else begin
         entry_blk = req_blk ^ eff_in_outer;
      end
   end

   assign side_in        = req_chan.mode[0] ? req_blk : entry_blk;
   assign req_chan.ready = advance && (!req_chained || (pend_ff == '0));
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      entry_item.valid       = accept;
      entry_item.decrypt     = req_chan.mode[0];
      entry_item.chained     = req_chained;
      entry_item.first_block = req_chan.first_block;
      entry_item.y           = entry_blk[63:32];
      entry_item.z           = entry_blk[31:0];
      entry_item.sum         = req_chan.mode[0] ? cfg.dec_sum : TEA_DELTA;
   end

   // cell row
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign cell_prev[i] = IDLE_ITEM;
      end else begin : g_link
         assign cell_prev[i] = cell_q[i-1];
      end

      tbc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .phase     (1'(i % 2)),
         .key       (cfg.key),
         .inject    (inject_idx == CELL_IDX_W'(i)),
         .inj_item  (entry_item),
         .prev_item (cell_prev[i]),
         .out_item  (cell_q[i])
      );
   end

   // exit side
   assign tail_item  = rounds_zero ? entry_item : cell_q[NUM_CELLS-1];
   assign tail_side  = rounds_zero ? side_in : side_ff;
   assign tail_blk   = {tail_item.y, tail_item.z};
   assign tail_inner = tail_item.first_block ? '0 : chain_inner_ff;
   assign tail_outer = tail_item.first_block ? '0 : chain_outer_ff;
   assign exit_word  = advance && tail_item.valid;

   always_comb begin
      if (!tail_item.chained) begin
         res = tail_blk;
      end else if (tail_item.decrypt) begin
         res = tail_blk ^ tail_outer;
      end else begin
         res = tail_blk ^ tail_inner;
      end
   end

   always_comb begin
      chain_inner_in = chain_inner_ff;
      chain_outer_in = chain_outer_ff;
      if (exit_word) begin
         if (tail_item.chained) begin
            if (tail_item.decrypt) begin
               chain_inner_in = tail_blk;
               chain_outer_in = tail_side;
            end else begin
               chain_inner_in = tail_side;
               chain_outer_in = res;
            end
         end else if (tail_item.first_block) begin
            chain_inner_in = '0;
            chain_outer_in = '0;
         end
      end
   end

   // chained or first-block words still in the cell row
   assign pend_inc = accept && (req_chained || req_chan.first_block) && !rounds_zero;
   assign pend_dec = exit_word && (tail_item.chained || tail_item.first_block) &&
                     !rounds_zero;

   always_comb begin
      case ({pend_inc, pend_dec})
         2'b10:   pend_in = pend_ff + 1'b1;
         2'b01:   pend_in = pend_ff - 1'b1;
         default: pend_in = pend_ff;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_high_in  = out_high_ff;
      out_low_in   = out_low_ff;
      if (advance) begin
         out_valid_in = tail_item.valid;
         out_high_in  = res[63:32];
         out_low_in   = res[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_inner_ff <= '0;
         chain_outer_ff <= '0;
         pend_ff        <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         chain_inner_ff <= chain_inner_in;
         chain_outer_ff <= chain_outer_in;
         pend_ff        <= pend_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_high_ff <= out_high_in;
      out_low_ff  <= out_low_in;
      if (accept && req_chained) begin
         side_ff <= side_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.result_high = out_high_ff;
   assign rsp_chan.result_low  = out_low_ff;

endmodule

// ----- sv/tbc_checker.sv -----
// ----------------------------------------------------------------------------
// TEA chained core checker
// Port-level properties of the result channel and register port.
// ----------------------------------------------------------------------------
`include "tea_block_cipher_chained_core_assert.svh"

module tbc_checker import tbc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [31:0]           rsp_result_high,
   input logic [31:0]           rsp_result_low,
   input logic                  csr_psel,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [31:0]           csr_prdata,
   input logic                  csr_pready
);

   `TBC_ASSERT_IMP(a_pready_high, clock, reset, 1'b1, csr_pready, "pready dropped")
   `TBC_ASSERT_IMP(a_rounds_read, clock, reset, csr_psel && !csr_pwrite && csr_paddr[4:2] == REG_ROUNDS, csr_prdata[31:7] == 25'd0, "round count readback too wide")
   `TBC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result word withdrawn")
   `TBC_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_result_high) && $stable(rsp_result_low), "stalled result word changed")

endmodule

bind tea_block_cipher_chained_core tbc_checker u_tbc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_result_high (rsp_chan.result_high),
   .rsp_result_low  (rsp_chan.result_low),
   .csr_psel        (csr_psel),
   .csr_pwrite      (csr_pwrite),
   .csr_paddr       (csr_paddr),
   .csr_prdata      (csr_prdata),
   .csr_pready      (csr_pready)
);
